### rtl/core/pcs_pkg.sv
// Shared constants, widths and helper functions for the PLL counter search block.
package pcs_pkg;

    localparam int unsigned FREQ_W = 48;
    localparam int unsigned CNT_W = 8;
    localparam int unsigned M_W = CNT_W + 1;
    localparam int unsigned DIV_W = 2 * CNT_W + 1;
    localparam int unsigned NUM_W = FREQ_W + CNT_W + 1;
    localparam int unsigned PROD_W = FREQ_W + DIV_W;
    localparam int unsigned WORD_W = 18;
    localparam int unsigned STEP_W = $clog2(NUM_W);

    localparam logic [CNT_W-1:0] COUNTER_MAX = CNT_W'(254);
    localparam logic [M_W-1:0] M_LAST = M_W'(COUNTER_MAX) + M_W'(1);
    localparam logic [FREQ_W-1:0] FREQ_SAT = '1;
    localparam logic [WORD_W-1:0] BYPASS_WORD = WORD_W'(18'h10000);

    function automatic logic [WORD_W-1:0] counter_word(input logic [CNT_W-1:0] x);
        return {{(WORD_W - 2 * CNT_W){1'b0}}, x, x};
    endfunction

endpackage

### rtl/core/pcs_div.sv
// Iterative restoring divider, one quotient bit per cycle, saturating quotient.
module pcs_div
    import pcs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  dividend,
    input  logic [DIV_W-1:0]  divisor,
    output logic              done,
    output logic [FREQ_W-1:0] quotient
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] count_reg, count_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [DIV_W-1:0]  dvs_reg, dvs_next;
    logic [DIV_W:0]    shifted;
    logic [DIV_W:0]    diff;
    logic              fits;

    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign fits = (shifted >= {1'b0, dvs_reg});
    assign diff = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        count_next = count_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            count_next = STEP_W'(NUM_W - 1);
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                count_next = count_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quotient = (quo_reg[NUM_W-1:FREQ_W] != '0) ? FREQ_SAT : quo_reg[FREQ_W-1:0];

`ifndef NO_ASSERTIONS
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg < dvs_reg))
        else $error("Partial remainder reached the divisor.");
    a_start_legal: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (!busy_reg && divisor != '0))
        else $error("Divider started while busy or with a zero divisor.");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (!busy_reg && $past(busy_reg)))
        else $error("Divider finished without running.");
`endif

endmodule

### rtl/core/pll_counter_search_core.sv
// Top level: sequencer that walks PLL counter rows with a shared multiplier and divider.
//
//  channel | handshake            | fields
//  in      | in_valid, in_ready   | ref_freq, target_freq
//  out     | out_valid, out_ready | m_word, n_word, c_word, achieved_freq, exact_match
//
// One item walks up to 64771 rows (one scale row, 254 ratio rows, 254 x 254 post rows).
// A row takes one or two passes of the shared 57-step divider and one or two binary
// searches. An exact match ends the search early. Reset clears the sequencer and the
// output valid. A new item is taken while a finished result still waits in the output
// register; a later result waits in the done state until that register is free.
module pll_counter_search_core
    import pcs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [FREQ_W-1:0] ref_freq,
    input  logic [FREQ_W-1:0] target_freq,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [WORD_W-1:0] m_word,
    output logic [WORD_W-1:0] n_word,
    output logic [WORD_W-1:0] c_word,
    output logic [FREQ_W-1:0] achieved_freq,
    output logic              exact_match
);

    typedef enum logic [3:0] {
        S_IDLE, S_ROW, S_TD, S_TDW, S_STEP, S_CMP,
        S_VMUL, S_VDIV, S_VWAIT, S_DECIDE, S_UPDATE, S_DONE
    } state_t;

    typedef enum logic [1:0] {PH_SCALE, PH_RATIO, PH_POST} phase_t;

    state_t            state_reg, state_next;
    logic              out_valid_reg, out_valid_next;
    logic [FREQ_W-1:0] ref_reg, ref_next;
    logic [FREQ_W-1:0] des_reg, des_next;
    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  c_reg, c_next;
    logic [DIV_W-1:0]  d_reg, d_next;
    logic              srch_ma_reg, srch_ma_next;
    logic [M_W-1:0]    lo_reg, lo_next;
    logic [M_W-1:0]    hi_reg, hi_next;
    logic [PROD_W-1:0] td_reg, td_next;
    logic              td_sat_reg, td_sat_next;
    logic [PROD_W-1:0] prod_reg;
    logic [M_W-1:0]    m_gt_reg, m_gt_next;
    logic [FREQ_W-1:0] va_reg, va_next;
    logic [FREQ_W-1:0] vb_reg, vb_next;
    logic              vsel_b_reg, vsel_b_next;
    logic [M_W-1:0]    pick_m_reg, pick_m_next;
    logic [FREQ_W-1:0] pick_val_reg, pick_val_next;
    logic [FREQ_W-1:0] pick_err_reg, pick_err_next;
    logic              best_valid_reg, best_valid_next;
    logic              best_exact_reg, best_exact_next;
    logic [FREQ_W-1:0] best_err_reg, best_err_next;
    logic [FREQ_W-1:0] best_freq_reg, best_freq_next;
    logic [WORD_W-1:0] best_mw_reg, best_mw_next;
    logic [WORD_W-1:0] best_nw_reg, best_nw_next;
    logic [WORD_W-1:0] best_cw_reg, best_cw_next;
    logic [WORD_W-1:0] mw_out_reg, mw_out_next;
    logic [WORD_W-1:0] nw_out_reg, nw_out_next;
    logic [WORD_W-1:0] cw_out_reg, cw_out_next;
    logic [FREQ_W-1:0] freq_out_reg, freq_out_next;
    logic              exact_out_reg, exact_out_next;

    logic [FREQ_W-1:0]  mul_a;
    logic [DIV_W-1:0]   mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic [FREQ_W:0]    des_inc;
    logic [M_W:0]       mid_sum;
    logic [M_W-1:0]     mid;
    logic [NUM_W-1:0]   num;
    logic               cmp_ge;
    logic [2*CNT_W-1:0] nc_prod;
    logic [DIV_W-1:0]   row_div;
    logic               have_a;
    logic               have_b;
    logic               pick_a;
    logic               take;
    logic               last_row;
    logic               div_start;
    logic               div_done;
    logic [FREQ_W-1:0]  div_q;

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign des_inc = {1'b0, des_reg} + (FREQ_W + 1)'(1);
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid = mid_sum[M_W:1];
    assign num = (phase_reg == PH_SCALE) ? {prod_reg[NUM_W-2:0], 1'b0} : prod_reg[NUM_W-1:0];
    assign cmp_ge = !td_sat_reg && (PROD_W'(num) >= td_reg);
    assign nc_prod = (2 * CNT_W)'(n_reg) * (2 * CNT_W)'(c_reg);
    assign have_a = (m_gt_reg > M_W'(1));
    assign have_b = (m_gt_reg <= M_W'(COUNTER_MAX));
    assign pick_a = have_a && (!have_b || ((des_reg - va_reg) <= (vb_reg - des_reg)));
    assign take = (pick_err_reg == '0) || !best_valid_reg || (pick_err_reg < best_err_reg);
    assign last_row = (phase_reg == PH_POST) && (n_reg == COUNTER_MAX) && (c_reg == COUNTER_MAX);

    always_comb
    begin
        unique case (phase_reg)
            PH_SCALE: row_div = DIV_W'(1);
            PH_RATIO: row_div = {{(DIV_W - CNT_W){1'b0}}, n_reg};
            PH_POST:  row_div = {nc_prod, 1'b0};
            default:  row_div = DIV_W'(1);
        endcase
    end

    pcs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num),
        .divisor  (d_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg;
        ref_next = ref_reg;
        des_next = des_reg;
        phase_next = phase_reg;
        n_next = n_reg;
        c_next = c_reg;
        d_next = d_reg;
        srch_ma_next = srch_ma_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        td_next = td_reg;
        td_sat_next = td_sat_reg;
        m_gt_next = m_gt_reg;
        va_next = va_reg;
        vb_next = vb_reg;
        vsel_b_next = vsel_b_reg;
        pick_m_next = pick_m_reg;
        pick_val_next = pick_val_reg;
        pick_err_next = pick_err_reg;
        best_valid_next = best_valid_reg;
        best_exact_next = best_exact_reg;
        best_err_next = best_err_reg;
        best_freq_next = best_freq_reg;
        best_mw_next = best_mw_reg;
        best_nw_next = best_nw_reg;
        best_cw_next = best_cw_reg;
        mw_out_next = mw_out_reg;
        nw_out_next = nw_out_reg;
        cw_out_next = cw_out_reg;
        freq_out_next = freq_out_reg;
        exact_out_next = exact_out_reg;
        mul_a = ref_reg;
        mul_b = {{(DIV_W - M_W){1'b0}}, mid};
        div_start = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ref_next = ref_freq;
                    des_next = target_freq;
                    phase_next = PH_SCALE;
                    n_next = CNT_W'(1);
                    c_next = CNT_W'(1);
                    best_valid_next = 1'b0;
                    best_exact_next = 1'b0;
                    state_next = S_ROW;
                end
            end
            S_ROW:
            begin
                d_next = row_div;
                srch_ma_next = 1'b0;
                state_next = S_TD;
            end
            S_TD:
            begin
                mul_a = srch_ma_reg ? va_reg : des_inc[FREQ_W-1:0];
                mul_b = d_reg;
                td_sat_next = !srch_ma_reg && des_inc[FREQ_W];
                lo_next = M_W'(1);
                hi_next = M_LAST;
                state_next = S_TDW;
            end
            S_TDW:
            begin
                td_next = prod_reg;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                if (lo_reg < hi_reg)
                begin
                    state_next = S_CMP;
                end
                else if (srch_ma_reg)
                begin
                    pick_m_next = lo_reg;
                    pick_val_next = va_reg;
                    pick_err_next = des_reg - va_reg;
                    state_next = S_UPDATE;
                end
                else
                begin
                    m_gt_next = lo_reg;
                    vsel_b_next = (lo_reg == M_W'(1));
                    state_next = S_VMUL;
                end
            end
            S_CMP:
            begin
                if (cmp_ge)
                begin
                    hi_next = mid;
                end
                else
                begin
                    lo_next = mid + M_W'(1);
                end
                state_next = S_STEP;
            end
            S_VMUL:
            begin
                mul_b = {{(DIV_W - M_W){1'b0}},
                         (vsel_b_reg ? m_gt_reg : (m_gt_reg - M_W'(1)))};
                state_next = S_VDIV;
            end
            S_VDIV:
            begin
                div_start = 1'b1;
                state_next = S_VWAIT;
            end
            S_VWAIT:
            begin
                if (div_done)
                begin
                    if (vsel_b_reg)
                    begin
                        vb_next = div_q;
                    end
                    else
                    begin
                        va_next = div_q;
                    end
                    if (!vsel_b_reg && have_b)
                    begin
                        vsel_b_next = 1'b1;
                        state_next = S_VMUL;
                    end
                    else
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end
            S_DECIDE:
            begin
                if (pick_a)
                begin
                    srch_ma_next = 1'b1;
                    state_next = S_TD;
                end
                else
                begin
                    pick_m_next = m_gt_reg;
                    pick_val_next = vb_reg;
                    pick_err_next = vb_reg - des_reg;
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                if (take)
                begin
                    best_valid_next = 1'b1;
                    best_err_next = pick_err_reg;
                    best_freq_next = pick_val_reg;
                    best_mw_next = counter_word(pick_m_reg[CNT_W-1:0]);
                    best_nw_next = (phase_reg != PH_SCALE) ? counter_word(n_reg) : BYPASS_WORD;
                    best_cw_next = (phase_reg == PH_POST) ? counter_word(c_reg) : BYPASS_WORD;
                end
                if (pick_err_reg == '0)
                begin
                    best_exact_next = 1'b1;
                    state_next = S_DONE;
                end
                else if (last_row)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_ROW;
                    unique case (phase_reg)
                        PH_SCALE:
                        begin
                            phase_next = PH_RATIO;
                            n_next = CNT_W'(1);
                        end
                        PH_RATIO:
                        begin
                            if (n_reg == COUNTER_MAX)
                            begin
                                phase_next = PH_POST;
                                n_next = CNT_W'(1);
                                c_next = CNT_W'(1);
                            end
                            else
                            begin
                                n_next = n_reg + CNT_W'(1);
                            end
                        end
                        PH_POST:
                        begin
                            if (n_reg == COUNTER_MAX)
                            begin
                                n_next = CNT_W'(1);
                                c_next = c_reg + CNT_W'(1);
                            end
                            else
                            begin
                                n_next = n_reg + CNT_W'(1);
                            end
                        end
                        default:
                        begin
                            phase_next = PH_SCALE;
                        end
                    endcase
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    mw_out_next = best_mw_reg;
                    nw_out_next = best_nw_reg;
                    cw_out_next = best_cw_reg;
                    freq_out_next = best_freq_reg;
                    exact_out_next = best_exact_reg;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ref_reg <= ref_next;
        des_reg <= des_next;
        phase_reg <= phase_next;
        n_reg <= n_next;
        c_reg <= c_next;
        d_reg <= d_next;
        srch_ma_reg <= srch_ma_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        td_reg <= td_next;
        td_sat_reg <= td_sat_next;
        prod_reg <= mul_p;
        m_gt_reg <= m_gt_next;
        va_reg <= va_next;
        vb_reg <= vb_next;
        vsel_b_reg <= vsel_b_next;
        pick_m_reg <= pick_m_next;
        pick_val_reg <= pick_val_next;
        pick_err_reg <= pick_err_next;
        best_valid_reg <= best_valid_next;
        best_exact_reg <= best_exact_next;
        best_err_reg <= best_err_next;
        best_freq_reg <= best_freq_next;
        best_mw_reg <= best_mw_next;
        best_nw_reg <= best_nw_next;
        best_cw_reg <= best_cw_next;
        mw_out_reg <= mw_out_next;
        nw_out_reg <= nw_out_next;
        cw_out_reg <= cw_out_next;
        freq_out_reg <= freq_out_next;
        exact_out_reg <= exact_out_next;
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign m_word = mw_out_reg;
    assign n_word = nw_out_reg;
    assign c_word = cw_out_reg;
    assign achieved_freq = freq_out_reg;
    assign exact_match = exact_out_reg;

`ifndef NO_ASSERTIONS
    a_search_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STEP) |->
            (lo_reg >= M_W'(1) && lo_reg <= hi_reg && hi_reg <= M_LAST))
        else $error("Binary search bounds left the counter range.");
    a_bracket: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE) |->
            ((!have_a || va_reg <= des_reg) && (!have_b || vb_reg > des_reg)))
        else $error("Row candidates do not bracket the desired frequency.");
    a_exact_value: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && best_exact_reg) |-> (best_freq_reg == des_reg))
        else $error("Exact match flagged on a frequency that differs from the target.");
    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_VWAIT))
        else $error("Divider finished outside the wait state.");
`endif

endmodule
